>>> src/gsa_pkg.sv
package gsa_pkg;

    // Sizing
    localparam int SLOTS = 256;
    localparam int GEN_W = 32;
    localparam int ID_W  = $clog2(SLOTS);
    localparam int CNT_W = $clog2(SLOTS + 1);

    // Operation codes
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // Status codes
    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_REJECT    = 2'd1;
    localparam logic [1:0] STAT_EXHAUSTED = 2'd2;

    typedef struct packed {
        logic            op;
        logic [ID_W-1:0] free_id;
    } t_gsa_req;

    typedef struct packed {
        logic [ID_W-1:0]  slot_id;
        logic [GEN_W-1:0] generation;
        logic [1:0]       status;
    } t_gsa_rsp;

    // Access to the generation store
    typedef struct packed {
        logic             rd_en;
        logic [ID_W-1:0]  rd_addr;
        logic             wr_en;
        logic [ID_W-1:0]  wr_addr;
        logic [GEN_W-1:0] wr_data;
    } t_gen_cmd;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_POP,
        ST_GEN
    } t_state;

endpackage

>>> src/gsa_gen_store.sv
module gsa_gen_store
    import gsa_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_gen_cmd         i_cmd,
    output logic [GEN_W-1:0] o_rd_data
);

    logic [GEN_W-1:0] mem [SLOTS];
    logic [SLOTS-1:0] r_vld;
    logic [GEN_W-1:0] r_rd_data;
    logic             r_rd_vld;

    // Write and read the generation array
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            mem[i_cmd.wr_addr] <= i_cmd.wr_data;
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= mem[i_cmd.rd_addr];
        end
    end

    // Track written entries; an unwritten entry reads as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_cmd.wr_en) begin
                r_vld[i_cmd.wr_addr] <= 1'b1;
            end
            if (i_cmd.rd_en) begin
                r_rd_vld <= r_vld[i_cmd.rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_vld ? r_rd_data : '0;

endmodule

>>> src/generational_slot_allocator.sv
// Responses: a rejected free or an exhausted allocate is answered from the idle state;
// a free or a fresh allocate passes through ST_GEN first; an allocate from the free
// stack passes through ST_POP, then ST_GEN (stack read, then generation read-modify-write).
// Transactions: one at a time, taken only in the idle state; the memory reads run in series.
// Reset: synchronous; clears the stack count and generation valid bits, sets the fresh id to 1.
// The result strobe lasts one cycle and the receiver cannot stall it.
module generational_slot_allocator
    import gsa_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     start,
    output logic     busy,
    input  t_gsa_req i_req,
    output logic     o_rsp_valid,
    output t_gsa_rsp o_rsp
);

    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [CNT_W-1:0]  r_fresh, n_fresh;
    logic [ID_W-1:0]   r_slot, n_slot;
    logic              r_op, n_op;
    logic              r_rsp_valid, n_rsp_valid;
    t_gsa_rsp          r_rsp, n_rsp;

    logic [ID_W-1:0]   stk_mem [SLOTS];
    logic [ID_W-1:0]   r_stk_rdata;
    logic              stk_wr_en;
    logic [ID_W-1:0]   stk_wr_addr;
    logic [ID_W-1:0]   stk_rd_addr;

    t_gen_cmd          gen_cmd;
    logic [GEN_W-1:0]  gen_rdata;
    logic [GEN_W-1:0]  gen_next;
    logic              accept;
    logic              free_ok;

    assign accept   = start && (r_state == ST_IDLE);
    assign free_ok  = (i_req.free_id != '0)
                   && ({1'b0, i_req.free_id} < r_fresh)
                   && (r_count < CNT_W'(SLOTS));
    assign gen_next = gen_rdata + GEN_W'(1);

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (i_req.op == OP_ALLOC) begin
                        if (r_count != '0) begin
                            n_state = ST_POP;
                        end else if (r_fresh < CNT_W'(SLOTS)) begin
                            n_state = ST_GEN;
                        end
                    end else if (free_ok) begin
                        n_state = ST_GEN;
                    end
                end
            end
            ST_POP:  n_state = ST_GEN;
            ST_GEN:  n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // Datapath, memory accesses and responses
    always_comb begin
        n_count     = r_count;
        n_fresh     = r_fresh;
        n_slot      = r_slot;
        n_op        = r_op;
        n_rsp_valid = 1'b0;
        n_rsp       = r_rsp;
        stk_wr_en   = 1'b0;
        stk_wr_addr = r_count[ID_W-1:0];
        stk_rd_addr = ID_W'(r_count - CNT_W'(1));
        gen_cmd     = '0;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_op = i_req.op;
                    if (i_req.op == OP_ALLOC) begin
                        if (r_count != '0) begin
                            n_count = r_count - CNT_W'(1);
                        end else if (r_fresh < CNT_W'(SLOTS)) begin
                            n_slot          = r_fresh[ID_W-1:0];
                            n_fresh         = r_fresh + CNT_W'(1);
                            gen_cmd.rd_en   = 1'b1;
                            gen_cmd.rd_addr = r_fresh[ID_W-1:0];
                        end else begin
                            n_rsp_valid = 1'b1;
                            n_rsp       = '{slot_id: '0, generation: '0,
                                            status: STAT_EXHAUSTED};
                        end
                    end else if (free_ok) begin
                        stk_wr_en       = 1'b1;
                        n_count         = r_count + CNT_W'(1);
                        n_slot          = i_req.free_id;
                        gen_cmd.rd_en   = 1'b1;
                        gen_cmd.rd_addr = i_req.free_id;
                    end else begin
                        n_rsp_valid = 1'b1;
                        n_rsp       = '{slot_id: '0, generation: '0, status: STAT_REJECT};
                    end
                end
            end
            ST_POP: begin
                n_slot          = r_stk_rdata;
                gen_cmd.rd_en   = 1'b1;
                gen_cmd.rd_addr = r_stk_rdata;
            end
            ST_GEN: begin
                gen_cmd.wr_en   = 1'b1;
                gen_cmd.wr_addr = r_slot;
                gen_cmd.wr_data = gen_next;
                n_rsp_valid     = 1'b1;
                if (r_op == OP_ALLOC) begin
                    n_rsp = '{slot_id: r_slot, generation: gen_next, status: STAT_OK};
                end else begin
                    n_rsp = '{slot_id: '0, generation: '0, status: STAT_OK};
                end
            end
            default: begin
                n_rsp_valid = 1'b0;
            end
        endcase
    end

    // Free stack memory
    always_ff @(posedge i_clk) begin
        if (stk_wr_en) begin
            stk_mem[stk_wr_addr] <= i_req.free_id;
        end
        r_stk_rdata <= stk_mem[stk_rd_addr];
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_fresh     <= CNT_W'(1);
            r_rsp_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_fresh     <= n_fresh;
            r_rsp_valid <= n_rsp_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_slot <= n_slot;
        r_op   <= n_op;
        r_rsp  <= n_rsp;
    end

    gsa_gen_store u_gen_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (gen_cmd),
        .o_rd_data (gen_rdata)
    );

    assign busy        = (r_state != ST_IDLE);
    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;

    // Checks
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(SLOTS))
        else $error("free stack count beyond capacity");

    a_fresh_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fresh != '0) && (r_fresh <= CNT_W'(SLOTS)))
        else $error("fresh id out of range");

    a_pop_then_gen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_POP) |=> (r_state == ST_GEN))
        else $error("stack pop not followed by generation update");

    a_rsp_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid |-> (r_state == ST_IDLE))
        else $error("response while a transaction is still in flight");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp_valid && (o_rsp.status != STAT_OK))
            |-> ((o_rsp.slot_id == '0) && (o_rsp.generation == '0)))
        else $error("failed transaction returned a nonzero slot or generation");

endmodule

>>> sim/tb_generational_slot_allocator.sv
module tb_generational_slot_allocator;
    import gsa_pkg::*;

    localparam int IDLE_LIMIT  = 1000;
    localparam int MAX_REPORTS = 10;

    logic     i_clk;
    logic     i_rst_n;
    logic     start;
    logic     busy;
    t_gsa_req i_req;
    logic     o_rsp_valid;
    t_gsa_rsp o_rsp;

    // Allocator state as predicted from accepted transactions
    logic [ID_W-1:0]  freed_ids [SLOTS];
    logic [GEN_W-1:0] slot_gen [SLOTS];
    bit               slot_live [SLOTS];
    int               freed_depth;
    int               fresh_next;

    // Predicted responses waiting for the DUT, oldest first
    t_gsa_rsp pending_rsp_q [$];

    int  err_count;
    int  exhaust_hits;
    int  full_rejects;
    int  idle_cycles;
    bit  no_gaps;

    generational_slot_allocator dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_req       (i_req),
        .o_rsp_valid (o_rsp_valid),
        .o_rsp       (o_rsp)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Apply one accepted transaction to the predicted state, return its response
    function automatic t_gsa_rsp apply_request(t_gsa_req req);
        t_gsa_rsp rsp;
        rsp = '0;
        rsp.status = STAT_OK;
        if (req.op == OP_ALLOC) begin
            if (freed_depth > 0) begin
                freed_depth--;
                rsp.slot_id = freed_ids[freed_depth];
                slot_gen[rsp.slot_id] = slot_gen[rsp.slot_id] + 1'b1;
                rsp.generation = slot_gen[rsp.slot_id];
                slot_live[rsp.slot_id] = 1'b1;
            end else if (fresh_next < SLOTS) begin
                rsp.slot_id = ID_W'(fresh_next);
                fresh_next++;
                slot_gen[rsp.slot_id] = slot_gen[rsp.slot_id] + 1'b1;
                rsp.generation = slot_gen[rsp.slot_id];
                slot_live[rsp.slot_id] = 1'b1;
            end else begin
                rsp.status = STAT_EXHAUSTED;
                exhaust_hits++;
            end
        end else if (req.free_id != '0 && int'(req.free_id) < fresh_next
                     && freed_depth < SLOTS) begin
            freed_ids[freed_depth] = req.free_id;
            freed_depth++;
            slot_gen[req.free_id] = slot_gen[req.free_id] + 1'b1;
            slot_live[req.free_id] = 1'b0;
        end else begin
            rsp.status = STAT_REJECT;
            if (freed_depth == SLOTS) full_rejects++;
        end
        return rsp;
    endfunction

    // Mostly short idle gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    function automatic logic [ID_W-1:0] pick_live_slot();
        logic [ID_W-1:0] live_ids [SLOTS];
        int              live_cnt;
        live_cnt = 0;
        for (int i = 1; i < SLOTS; i++) begin
            if (slot_live[i]) begin
                live_ids[live_cnt] = ID_W'(i);
                live_cnt++;
            end
        end
        if (live_cnt == 0) return '0;
        return live_ids[$urandom_range(0, live_cnt - 1)];
    endfunction

    // Drive one transaction, wait for acceptance, record its predicted response
    task automatic send_req(input logic op, input logic [ID_W-1:0] id);
        t_gsa_req req;
        int       gap;
        req.op      = op;
        req.free_id = id;
        gap = no_gaps ? 0 : pick_gap();
        if (gap > 0) begin
            @(negedge i_clk);
            start <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        start <= 1'b1;
        i_req <= req;
        do @(posedge i_clk); while (busy !== 1'b0);
        pending_rsp_q.insert(pending_rsp_q.size(), apply_request(req));
    endtask

    // One random transaction; free_pct sets the share of frees
    task automatic send_random(input int free_pct);
        logic [ID_W-1:0] id;
        int              k;
        if ($urandom_range(0, 99) >= free_pct) begin
            send_req(OP_ALLOC, ID_W'($urandom_range(0, SLOTS - 1)));
        end else begin
            k  = $urandom_range(0, 99);
            id = '0;
            if (k < 70) id = pick_live_slot();
            if (id == '0) begin
                if (k < 88 && fresh_next > 1)
                    id = ID_W'($urandom_range(1, fresh_next - 1));
                else
                    id = ID_W'($urandom_range(0, SLOTS - 1));
            end
            send_req(OP_FREE, id);
        end
    endtask

    task automatic pick_idle_mode(input int n);
        if (n % 64 == 0) no_gaps = ($urandom_range(0, 3) == 0);
    endtask

    // Rejects out of reset, fresh issue, reuse from the stack, double free
    task automatic test_corner_cases();
        send_req(OP_FREE, '0);
        send_req(OP_FREE, '1);
        send_req(OP_FREE, ID_W'(1));
        send_req(OP_ALLOC, '1);
        send_req(OP_ALLOC, '0);
        send_req(OP_ALLOC, ID_W'(8'hA5));
        send_req(OP_FREE, ID_W'(2));
        send_req(OP_FREE, ID_W'(2));
        send_req(OP_ALLOC, '0);
        send_req(OP_ALLOC, '0);
        send_req(OP_ALLOC, '0);
        send_req(OP_FREE, ID_W'(fresh_next));
        send_req(OP_FREE, ID_W'(fresh_next - 1));
        send_req(OP_FREE, ID_W'(1));
        send_req(OP_FREE, '0);
        send_req(OP_ALLOC, ID_W'(8'h5A));
        send_req(OP_ALLOC, '1);
    endtask

    // Balanced allocate and free traffic at low occupancy
    task automatic test_churn();
        for (int n = 0; n < 600; n++) begin
            pick_idle_mode(n);
            send_random(45);
        end
    endtask

    // Allocate-heavy until the fresh range runs out and allocates are refused
    task automatic test_exhaust();
        int extra;
        extra = 0;
        for (int n = 0; n < 3000 && extra < 100; n++) begin
            pick_idle_mode(n);
            send_random(15);
            if (exhaust_hits >= 20) extra++;
        end
    endtask

    // Free-heavy with double frees until the stack is full and frees bounce
    task automatic test_stack_fill();
        int extra;
        extra = 0;
        for (int n = 0; n < 3000 && extra < 100; n++) begin
            pick_idle_mode(n);
            send_random(88);
            if (full_rejects >= 20) extra++;
        end
    endtask

    // Drain back down with mixed traffic
    task automatic test_mixed();
        for (int n = 0; n < 500; n++) begin
            pick_idle_mode(n);
            send_random(n < 250 ? 30 : 55);
        end
    endtask

    // Check each response against the oldest prediction
    always @(posedge i_clk) begin
        t_gsa_rsp exp_rsp;
        if (i_rst_n && o_rsp_valid === 1'b1) begin
            if (pending_rsp_q.size() == 0) begin
                err_count++;
                if (err_count <= MAX_REPORTS)
                    $display("unexpected response: slot %0d gen %0d status %0d",
                             o_rsp.slot_id, o_rsp.generation, o_rsp.status);
            end else begin
                exp_rsp = pending_rsp_q.pop_front();
                if (o_rsp.slot_id !== exp_rsp.slot_id
                    || o_rsp.generation !== exp_rsp.generation
                    || o_rsp.status !== exp_rsp.status) begin
                    err_count++;
                    if (err_count <= MAX_REPORTS)
                        $display("mismatch: exp slot %0d gen %0d status %0d, got slot %0d gen %0d status %0d",
                                 exp_rsp.slot_id, exp_rsp.generation, exp_rsp.status,
                                 o_rsp.slot_id, o_rsp.generation, o_rsp.status);
                end
            end
        end
    end

    // Stop a hung run: no transaction accepted and no response for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && busy === 1'b0) || o_rsp_valid === 1'b1) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    initial begin
        i_rst_n      = 1'b0;
        start        = 1'b0;
        i_req        = '0;
        err_count    = 0;
        exhaust_hits = 0;
        full_rejects = 0;
        idle_cycles  = 0;
        no_gaps      = 1'b0;
        freed_depth  = 0;
        fresh_next   = 1;
        for (int i = 0; i < SLOTS; i++) begin
            freed_ids[i] = '0;
            slot_gen[i]  = '0;
            slot_live[i] = 1'b0;
        end

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_corner_cases();
        test_churn();
        test_exhaust();
        test_stack_fill();
        test_mixed();

        // Let the last responses drain, then allow for the slowest latency
        @(negedge i_clk);
        start <= 1'b0;
        while (pending_rsp_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        if (err_count == 0 && pending_rsp_q.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

>>> filelist.f
src/gsa_pkg.sv
src/gsa_gen_store.sv
src/generational_slot_allocator.sv
sim/tb_generational_slot_allocator.sv
